// File: sv/lrgc_pkg.sv
// ----------------------------------------------------------------------------
// lrgc_pkg
// Shared types and constants for the lidar ray ground classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package lrgc_pkg;

    localparam int RADIUS_W = 17;
    localparam int HEIGHT_W = 16;
    localparam int INDEX_W  = 16;
    localparam int SLOPE_W  = 16;
    localparam int BAND_W   = 16;
    localparam int DIST_W   = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TAN_GENERAL = 3'd0,
        REG_TAN_LOCAL   = 3'd1,
        REG_TAN_INITIAL = 3'd2,
        REG_MIN_BAND    = 3'd3,
        REG_HOLD_DIST   = 3'd4,
        REG_RECLASS     = 3'd5
    } t_cfg_reg;

    localparam logic [SLOPE_W-1:0] RST_TAN_GENERAL = 16'd9210;
    localparam logic [SLOPE_W-1:0] RST_TAN_LOCAL   = 16'd6888;
    localparam logic [SLOPE_W-1:0] RST_TAN_INITIAL = 16'd3435;
    localparam logic [BAND_W-1:0]  RST_MIN_BAND    = 16'd150;
    localparam logic [DIST_W-1:0]  RST_HOLD_DIST   = 17'd0;
    localparam logic [DIST_W-1:0]  RST_RECLASS     = 17'd100;

    typedef struct packed {
        logic [RADIUS_W-1:0]        radius_mm;
        logic signed [HEIGHT_W-1:0] height_mm;
        logic                       first_in_ray;
        logic [INDEX_W-1:0]         point_index;
    } t_in_item;

    typedef struct packed {
        logic [INDEX_W-1:0] index_out;
        logic               is_ground;
    } t_out_item;

    typedef struct packed {
        logic [SLOPE_W-1:0] tan_general_slope;
        logic [SLOPE_W-1:0] tan_local_slope;
        logic [SLOPE_W-1:0] tan_initial_slope;
        logic [BAND_W-1:0]  min_height_band;
        logic [DIST_W-1:0]  hold_distance;
        logic [DIST_W-1:0]  reclass_distance;
    } t_cfg;

    typedef struct packed {
        logic [RADIUS_W-1:0]        last_radius;
        logic signed [HEIGHT_W-1:0] last_height;
        logic                       last_was_ground;
    } t_hist;

endpackage

`default_nettype wire

// File: sv/lrgc_cfg_regs.sv
// ----------------------------------------------------------------------------
// lrgc_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module lrgc_cfg_regs
    import lrgc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_TAN_GENERAL: n_cfg.tan_general_slope = i_cfg_data[SLOPE_W-1:0];
                REG_TAN_LOCAL:   n_cfg.tan_local_slope   = i_cfg_data[SLOPE_W-1:0];
                REG_TAN_INITIAL: n_cfg.tan_initial_slope = i_cfg_data[SLOPE_W-1:0];
                REG_MIN_BAND:    n_cfg.min_height_band   = i_cfg_data[BAND_W-1:0];
                REG_HOLD_DIST:   n_cfg.hold_distance     = i_cfg_data[DIST_W-1:0];
                REG_RECLASS:     n_cfg.reclass_distance  = i_cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tan_general_slope <= RST_TAN_GENERAL;
            r_cfg.tan_local_slope   <= RST_TAN_LOCAL;
            r_cfg.tan_initial_slope <= RST_TAN_INITIAL;
            r_cfg.min_height_band   <= RST_MIN_BAND;
            r_cfg.hold_distance     <= RST_HOLD_DIST;
            r_cfg.reclass_distance  <= RST_RECLASS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: sv/lrgc_decide.sv
// ----------------------------------------------------------------------------
// lrgc_decide
// Ground decision for one point: local band, general cone, hold and
// reclassify rules; band and cone are compared exactly with Q0.16 slopes.
// ----------------------------------------------------------------------------
`default_nettype none

module lrgc_decide
    import lrgc_pkg::*;
(
    input  wire t_in_item i_item,
    input  wire t_cfg     i_cfg,
    input  wire t_hist    i_hist,
    output logic          o_ground
);

    logic [RADIUS_W-1:0]        prev_r;
    logic signed [HEIGHT_W-1:0] prev_h;
    logic                       prev_g;
    logic [SLOPE_W-1:0]         slope;

    logic signed [RADIUS_W:0]   rstep;
    logic signed [34:0]         band_raw;
    logic signed [34:0]         floor_band;
    logic signed [34:0]         band;
    logic signed [HEIGHT_W:0]   dh;
    logic [HEIGHT_W:0]          abs_dh;
    logic signed [34:0]         dh_scaled;
    logic [HEIGHT_W-1:0]        abs_h;
    logic [32:0]                cone_lhs;
    logic [32:0]                cone_rhs;
    logic                       in_cone;
    logic                       held;
    logic                       in_band;
    logic                       gap_met;

    always_comb begin
        prev_r = i_item.first_in_ray ? '0   : i_hist.last_radius;
        prev_h = i_item.first_in_ray ? '0   : i_hist.last_height;
        prev_g = i_item.first_in_ray ? 1'b0 : i_hist.last_was_ground;
        slope  = i_item.first_in_ray ? i_cfg.tan_initial_slope : i_cfg.tan_local_slope;

        rstep      = $signed({1'b0, i_item.radius_mm}) - $signed({1'b0, prev_r});
        band_raw   = 35'($signed({1'b0, slope})) * 35'(rstep);
        floor_band = $signed({3'b000, i_cfg.min_height_band, 16'h0000});
        band       = (band_raw < floor_band) ? floor_band : band_raw;

        dh        = $signed({i_item.height_mm[HEIGHT_W-1], i_item.height_mm})
                  - $signed({prev_h[HEIGHT_W-1], prev_h});
        abs_dh    = dh[HEIGHT_W] ? 17'(-dh) : 17'(dh);
        dh_scaled = $signed({2'b00, abs_dh, 16'h0000});

        abs_h    = i_item.height_mm[HEIGHT_W-1] ? 16'(-i_item.height_mm)
                                                : 16'(i_item.height_mm);
        cone_lhs = {1'b0, abs_h, 16'h0000};
        cone_rhs = 33'(i_cfg.tan_general_slope) * 33'(i_item.radius_mm);
        in_cone  = cone_lhs <= cone_rhs;

        held    = rstep < $signed({1'b0, i_cfg.hold_distance});
        in_band = dh_scaled <= band;
        gap_met = rstep > $signed({1'b0, i_cfg.reclass_distance});

        if (held) begin
            o_ground = prev_g;
        end else if (in_band) begin
            o_ground = prev_g | in_cone;
        end else begin
            o_ground = gap_met & in_cone;
        end
    end

endmodule

`default_nettype wire

// File: sv/lidar_ray_ground_classifier_top.sv
// ----------------------------------------------------------------------------
// lidar_ray_ground_classifier_top
// Classifies lidar points along one ray as ground or obstacle.
//
//   channel  direction  handshake                   payload
//   in       input      i_in_valid / o_in_stall     i_in_data  (t_in_item)
//   out      output     o_out_valid / i_out_stall   o_out_data (t_out_item)
//   cfg      input      i_cfg_we                    i_cfg_idx, i_cfg_data
//
// One transaction per cycle while no stall holds the flow. A point waits in
// the input register, is classified against the ray history and lands in
// the result register; the history register is updated through the
// decision logic as the point moves on. Synchronous reset clears the
// valids and the history, not the data registers. A stalled result holds
// while the input register keeps accepting until it is full too.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_ray_ground_classifier_top
    import lrgc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_item                  o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      cfg;
    t_in_item  r_in;
    logic      r_in_vld;
    t_out_item r_out;
    logic      r_out_vld;
    t_hist     r_hist;
    t_hist     n_hist;
    logic      ground;
    logic      advance;
    logic      load;

    lrgc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    lrgc_decide u_decide (
        .i_item   (r_in),
        .i_cfg    (cfg),
        .i_hist   (r_hist),
        .o_ground (ground)
    );

    assign advance    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !advance;
    assign load       = i_in_valid && !o_in_stall;

    always_comb begin
        n_hist = r_hist;
        if (advance) begin
            n_hist.last_radius     = r_in.radius_mm;
            n_hist.last_height     = r_in.height_mm;
            n_hist.last_was_ground = ground;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_hist    <= '0;
        end else begin
            r_hist <= n_hist;
            if (load) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out.index_out <= r_in.point_index;
            r_out.is_ground <= ground;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lidar_ray_ground_classifier_top.
//
// Rays of points, mostly well formed with random steps and heights, plus
// noise points, are queued by the sequencer in phases. Each phase runs with
// its own register setting and its own idling pattern. A clocked driver feeds
// the input channel in bursts with random gaps. A clocked monitor predicts
// the ground decision of every accepted transaction and checks each result
// against the oldest prediction. The receiver stalls on a per-phase pattern.
// ----------------------------------------------------------------------------

module tb;
    import lrgc_pkg::*;

    localparam int LIMIT = 200000;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_BURST,
        STALL_PERIODIC
    } t_stall_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = REG_TAN_GENERAL;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    t_in_item    point_q[$];
    t_out_item   verdict_q[$];
    t_cfg        cfg_shadow;
    t_hist       ray_hist;
    logic        in_taken = 1'b0;
    int          err_cnt = 0;
    int          cycles = 0;
    int          gap_max = 0;
    int          gap_left = 0;
    int          burst_left = 1;
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_run = 0;
    logic        stall_level = 1'b0;
    int          stall_tick = 0;

    lidar_ray_ground_classifier_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint abs_mm(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic bit in_cone(longint h, longint r);
        return abs_mm(h) * 65536 <= longint'(cfg_shadow.tan_general_slope) * r;
    endfunction

    // Ground decision for one point; advances the ray history.
    function automatic t_out_item classify_point(t_in_item p);
        longint    r, h, prev_r, prev_h, slope, rstep, band, floor_band;
        logic      prev_g, gnd;
        t_out_item res;
        r      = longint'(p.radius_mm);
        h      = longint'($signed(p.height_mm));
        prev_r = p.first_in_ray ? 0 : longint'(ray_hist.last_radius);
        prev_h = p.first_in_ray ? 0 : longint'($signed(ray_hist.last_height));
        prev_g = p.first_in_ray ? 1'b0 : ray_hist.last_was_ground;
        slope  = p.first_in_ray ? longint'(cfg_shadow.tan_initial_slope)
                                : longint'(cfg_shadow.tan_local_slope);
        rstep      = r - prev_r;
        band       = slope * rstep;
        floor_band = longint'(cfg_shadow.min_height_band) * 65536;
        if (band < floor_band) begin
            band = floor_band;
        end
        if (rstep < longint'(cfg_shadow.hold_distance)) begin
            gnd = prev_g;
        end else if (abs_mm(h - prev_h) * 65536 <= band) begin
            gnd = prev_g ? 1'b1 : in_cone(h, r);
        end else begin
            gnd = (rstep > longint'(cfg_shadow.reclass_distance)) && in_cone(h, r);
        end
        ray_hist.last_radius     = p.radius_mm;
        ray_hist.last_height     = p.height_mm;
        ray_hist.last_was_ground = gnd;
        res.index_out = p.point_index;
        res.is_ground = gnd;
        return res;
    endfunction

    initial begin
        cfg_shadow.tan_general_slope = RST_TAN_GENERAL;
        cfg_shadow.tan_local_slope   = RST_TAN_LOCAL;
        cfg_shadow.tan_initial_slope = RST_TAN_INITIAL;
        cfg_shadow.min_height_band   = RST_MIN_BAND;
        cfg_shadow.hold_distance     = RST_HOLD_DIST;
        cfg_shadow.reclass_distance  = RST_RECLASS;
        ray_hist = '0;
    end

    // Input acceptance, prediction and result checking.
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                verdict_q = {verdict_q, classify_point(i_in_data)};
            end
            if (o_out_valid && !i_out_stall) begin
                if (verdict_q.size() == 0) begin
                    $error("unexpected result: index_out %0d is_ground %0b",
                           o_out_data.index_out, o_out_data.is_ground);
                    err_cnt++;
                end else begin
                    want = verdict_q.pop_front();
                    if (o_out_data.index_out !== want.index_out) begin
                        $error("index_out: expected %0d, actual %0d",
                               want.index_out, o_out_data.index_out);
                        err_cnt++;
                    end
                    if (o_out_data.is_ground !== want.is_ground) begin
                        $error("is_ground: expected %0b, actual %0b (index %0d)",
                               want.is_ground, o_out_data.is_ground, want.index_out);
                        err_cnt++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("lidar_ray_ground_classifier_top regression: fail");
            $finish;
        end
    end

    // Driver: bursts of transactions separated by random gaps.
    always @(negedge i_clk) begin
        if (i_rst_n && (in_taken || !i_in_valid)) begin
            if (gap_left != 0) begin
                gap_left = gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (point_q.size() != 0) begin
                i_in_data  <= point_q.pop_front();
                i_in_valid <= 1'b1;
                burst_left = burst_left - 1;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        stall_tick = stall_tick + 1;
        case (stall_mode)
            STALL_NONE: begin
                i_out_stall <= 1'b0;
            end
            STALL_RANDOM: begin
                i_out_stall <= ($urandom_range(0, 99) < 35);
            end
            STALL_BURST: begin
                if (stall_run <= 0) begin
                    stall_run   = $urandom_range(1, 20);
                    stall_level = ~stall_level;
                end
                stall_run = stall_run - 1;
                i_out_stall <= stall_level;
            end
            default: begin
                i_out_stall <= ((stall_tick % 7) < 3);
            end
        endcase
    end

    task automatic write_reg(input t_cfg_reg r, input logic [CFG_DATA_W-1:0] d);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= r;
        i_cfg_data <= d;
    endtask

    task automatic set_cfg(input t_cfg c);
        write_reg(REG_TAN_GENERAL, CFG_DATA_W'(c.tan_general_slope));
        write_reg(REG_TAN_LOCAL,   CFG_DATA_W'(c.tan_local_slope));
        write_reg(REG_TAN_INITIAL, CFG_DATA_W'(c.tan_initial_slope));
        write_reg(REG_MIN_BAND,    CFG_DATA_W'(c.min_height_band));
        write_reg(REG_HOLD_DIST,   c.hold_distance);
        write_reg(REG_RECLASS,     c.reclass_distance);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_shadow = c;
    endtask

    // Returns at a falling edge once every queued point has its result.
    task automatic drain();
        do @(posedge i_clk); while (point_q.size() != 0);
        do @(negedge i_clk); while (i_in_valid || verdict_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic void push_pt(int r, int h, bit first, int idx = -1);
        t_in_item p;
        p.radius_mm    = RADIUS_W'(r);
        p.height_mm    = HEIGHT_W'(h);
        p.first_in_ray = first;
        p.point_index  = (idx < 0) ? INDEX_W'($urandom_range(0, 65535)) : INDEX_W'(idx);
        point_q = {point_q, p};
    endfunction

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void push_noise();
        t_in_item p;
        p.radius_mm    = RADIUS_W'($urandom);
        p.height_mm    = HEIGHT_W'($urandom);
        p.first_in_ray = 1'($urandom_range(0, 1));
        p.point_index  = INDEX_W'($urandom);
        point_q = {point_q, p};
    endfunction

    // One ray in roughly ascending radius, height following the terrain.
    function automatic int push_ray(int len);
        int r, h, step;
        r = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 131071))
                                        : int'($urandom_range(0, 3000));
        h = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535)) - 32768
                                        : int'($urandom_range(0, 400)) - 200;
        for (int i = 0; i < len; i++) begin
            push_pt(r, h, i == 0);
            case ($urandom_range(0, 9))
                0:       step = 0;
                1:       step = -int'($urandom_range(1, 500));
                2, 3:    step = $urandom_range(1, 60);
                8:       step = $urandom_range(600, 20000);
                9:       step = $urandom_range(0, 131071);
                default: step = $urandom_range(60, 600);
            endcase
            r = clamp(r + step, 0, 131071);
            case ($urandom_range(0, 7))
                0:       h = int'($urandom_range(0, 65535)) - 32768;
                1:       h = h + int'($urandom_range(0, 4000)) - 2000;
                default: h = h + int'($urandom_range(0, 200)) - 100;
            endcase
            h = clamp(h, -32768, 32767);
        end
        return len;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_val(int unsigned typ_max,
                                                       int unsigned full_max);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return CFG_DATA_W'(full_max);
            2:       return CFG_DATA_W'($urandom_range(0, full_max));
            default: return CFG_DATA_W'($urandom_range(0, typ_max));
        endcase
    endfunction

    function automatic t_cfg random_cfg();
        t_cfg c;
        c.tan_general_slope = SLOPE_W'(pick_val(30000, 65535));
        c.tan_local_slope   = SLOPE_W'(pick_val(30000, 65535));
        c.tan_initial_slope = SLOPE_W'(pick_val(30000, 65535));
        c.min_height_band   = BAND_W'(pick_val(500, 65535));
        c.hold_distance     = pick_val(300, 131071);
        c.reclass_distance  = pick_val(1000, 131071);
        return c;
    endfunction

    initial begin : sequencer
        t_cfg c;
        int   n;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed points under reset settings.
        @(posedge i_clk);
        push_pt(0, 0, 1, 0);
        push_pt(0, 0, 0, 65535);
        push_pt(131071, 32767, 0);
        push_pt(131071, -32768, 1);
        push_pt(131071, -32768, 0);
        push_pt(1000, 0, 1);
        push_pt(1500, 50, 0);
        push_pt(1400, 60, 0);
        push_pt(1600, 900, 0);
        push_pt(1650, 100, 0);
        push_pt(3000, 150, 0);
        push_pt(3050, 170, 0);
        push_pt(3060, 5000, 0);
        push_pt(500, 70, 1);
        push_pt(500, -80, 1);
        push_pt(20000, -30000, 0);
        drain();

        // Hold rule and reclassification with no gap threshold.
        c = cfg_shadow;
        c.hold_distance    = 200;
        c.reclass_distance = 0;
        set_cfg(c);
        @(posedge i_clk);
        push_pt(1000, 0, 1);
        push_pt(1100, 3000, 0);
        push_pt(1400, 3000, 0);
        push_pt(1401, 3000, 0);
        push_pt(1700, -3000, 0);
        push_pt(1200, 20, 0);
        push_pt(1500, 40, 0);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: c = '0;
                1: c = '1;
                2: begin
                    c.tan_general_slope = RST_TAN_GENERAL;
                    c.tan_local_slope   = RST_TAN_LOCAL;
                    c.tan_initial_slope = RST_TAN_INITIAL;
                    c.min_height_band   = RST_MIN_BAND;
                    c.hold_distance     = RST_HOLD_DIST;
                    c.reclass_distance  = RST_RECLASS;
                end
                default: c = random_cfg();
            endcase
            set_cfg(c);
            @(posedge i_clk);
            stall_mode = (ph == 3) ? STALL_NONE : t_stall_mode'($urandom_range(0, 3));
            gap_max    = (ph % 3 == 0) ? 0 : $urandom_range(1, 8);
            n = 0;
            while (n < 45) begin
                if ($urandom_range(0, 9) == 0) begin
                    push_noise();
                    n++;
                end else begin
                    n += push_ray((ph == 5) ? 40 : $urandom_range(1, 12));
                end
            end
            drain();
        end

        repeat (10) @(negedge i_clk);
        if (err_cnt == 0) begin
            $display("lidar_ray_ground_classifier_top regression: pass");
        end else begin
            $display("lidar_ray_ground_classifier_top regression: fail");
        end
        $finish;
    end

endmodule
